/* rtl/ove_pkg.sv */
// Shared types and constants for the organ voice envelope block.
// Item structs, register indexes, divider request/response and the per-envelope plan.
// No dependencies.
package ove_pkg;

    localparam int VOICES_DEFAULT = 32;

    localparam int TIME_W  = 32;
    localparam int LEVEL_W = 16;
    localparam int VOICE_W = 5;
    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'h8000;
    localparam logic [LEVEL_W-1:0] END_LEVEL = 16'd50;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_ATTACK       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DECAY        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SUSTAIN      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PERC_ATTACK  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PERC_DECAY   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PERC_RELEASE = 3'd6;

    // Register reset values
    localparam logic [TIME_W-1:0]  ATTACK_RST       = 32'd16777;
    localparam logic [TIME_W-1:0]  DECAY_RST        = 32'd1677722;
    localparam logic [LEVEL_W-1:0] SUSTAIN_RST      = 16'd16384;
    localparam logic [TIME_W-1:0]  RELEASE_RST      = 32'd10066330;
    localparam logic [TIME_W-1:0]  PERC_ATTACK_RST  = 32'd16777;
    localparam logic [TIME_W-1:0]  PERC_DECAY_RST   = 32'd1677722;
    localparam logic [TIME_W-1:0]  PERC_RELEASE_RST = 32'd10066330;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic               gate;
        logic               pedal;
        logic [TIME_W-1:0]  elapsed_time;
    } in_item_t;

    typedef struct packed {
        logic [VOICE_W-1:0] voice_out;
        logic [LEVEL_W-1:0] main_level;
        logic [LEVEL_W-1:0] perc_level;
        logic               voice_ended;
    } out_item_t;

    // Request to the multiply-divide unit: floor(m * x / den)
    typedef struct packed {
        logic               start;
        logic [LEVEL_W-1:0] m;
        logic [TIME_W-1:0]  x;
        logic [TIME_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] q;
    } div_rsp_t;

    // How one envelope level is formed from a quotient or a fixed value
    typedef struct packed {
        logic               use_div;
        logic               invert;   // level = one - quotient
        logic               rel_end;  // quiet release ends the voice
        logic               ended;
        logic [LEVEL_W-1:0] value;
        logic [LEVEL_W-1:0] m;
        logic [TIME_W-1:0]  x;
        logic [TIME_W-1:0]  den;
    } plan_t;

endpackage

/* rtl/ove_muldiv.sv */
// Multiply-then-divide unit: floor(m * x / den) with a 16-bit quotient.
// A 16x32 multiply, then 16 restoring steps, one quotient bit each.
// Depends on ove_pkg.
module ove_muldiv
(
    input  logic              clk,
    input  logic              rst_n,
    input  ove_pkg::div_req_t req,
    output ove_pkg::div_rsp_t rsp
);

    logic                        mul_reg;
    logic                        run_reg;
    logic                        done_reg;
    logic [3:0]                  cnt_reg;
    logic [ove_pkg::LEVEL_W-1:0] m_reg;
    logic [ove_pkg::TIME_W-1:0]  x_reg;
    logic [ove_pkg::TIME_W-1:0]  den_reg;
    logic [ove_pkg::TIME_W-1:0]  rem_reg;
    logic [ove_pkg::LEVEL_W-1:0] quo_reg;

    logic [ove_pkg::TIME_W+ove_pkg::LEVEL_W-1:0] prod;
    logic [ove_pkg::TIME_W:0]                    trial;
    logic [ove_pkg::TIME_W:0]                    diff;
    logic                                        ge;

    assign prod  = m_reg * x_reg;
    assign trial = {rem_reg, quo_reg[ove_pkg::LEVEL_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == 4'd15);
            if (req.start)
            begin
                mul_reg <= 1'b1;
            end
            else if (mul_reg)
            begin
                mul_reg <= 1'b0;
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            m_reg   <= req.m;
            x_reg   <= req.x;
            den_reg <= req.den;
        end
        else if (mul_reg)
        begin
            // the quotient fits 16 bits, so the upper product bits stay below den
            rem_reg <= prod[ove_pkg::TIME_W+ove_pkg::LEVEL_W-1:ove_pkg::LEVEL_W];
            quo_reg <= prod[ove_pkg::LEVEL_W-1:0];
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[ove_pkg::TIME_W-1:0] : trial[ove_pkg::TIME_W-1:0];
            quo_reg <= {quo_reg[ove_pkg::LEVEL_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = quo_reg;

endmodule

/* rtl/organ_voice_envelope.sv */
// Organ voice envelope: main ADSR envelope with sustain pedal and percussive envelope
// per voice, with per-voice level stores in one synchronous memory.
// Depends on ove_pkg and ove_muldiv.
//
// Usage:
//   Input channel in_valid/in_stall/in_item carries voice, gate, pedal and elapsed
//   time; output channel out_valid/out_stall/out_item returns both levels and the
//   end-of-voice flag for that voice, one result per item, in order.
//   cfg_write/cfg_index/cfg_data write the seven envelope registers; write them only
//   while the block is idle.
//   One item is worked on at a time: the input stalls until the item's result has
//   been loaded into the output register. The shared multiply-divide unit runs once
//   for the main and once for the percussive level (operand latch, the multiply,
//   16 quotient steps); then the last quotient is captured and the output register
//   is loaded.
//   The result sits in an output register, so the next item is taken while it waits.
//   If the receiver stalls and a second result is ready, the block holds it and
//   stalls its input until the output register frees.
//   Reset loads the register defaults and marks every store entry invalid, so all
//   voices read level zero until written.
module organ_voice_envelope
#(
    parameter int VOICES = ove_pkg::VOICES_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  ove_pkg::in_item_t              in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output ove_pkg::out_item_t             out_item,
    input  logic                           cfg_write,
    input  logic [ove_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [ove_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SW = 2 * ove_pkg::LEVEL_W;

    typedef enum logic [4:0]
    {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_MDIV = 5'b00100,
        S_PDIV = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [ove_pkg::TIME_W-1:0]  attack_reg, decay_reg, release_reg;
    logic [ove_pkg::TIME_W-1:0]  perc_attack_reg, perc_decay_reg, perc_release_reg;
    logic [ove_pkg::LEVEL_W-1:0] sustain_reg;

    logic [SW-1:0]     mem [VOICES];
    logic [VOICES-1:0] vld_reg;
    logic [SW-1:0]     rd_data_reg;
    logic              rd_ok_reg;
    logic              wr_ok_reg;

    ove_pkg::in_item_t  item_reg;
    ove_pkg::plan_t     plan_m_reg, plan_p_reg;
    ove_pkg::plan_t     plan_m, plan_p;
    logic [ove_pkg::LEVEL_W-1:0] mq_reg, pq_reg;

    ove_pkg::out_item_t out_reg;
    logic               out_valid_reg;

    ove_pkg::div_req_t  div_req;
    ove_pkg::div_rsp_t  div_rsp;

    logic              in_take;
    logic              out_load;
    logic              voice_ok;
    logic [AW-1:0]     in_addr;
    logic [AW-1:0]     wr_addr;
    logic [ove_pkg::LEVEL_W-1:0] sus;
    logic [ove_pkg::LEVEL_W-1:0] mstore, pstore;
    logic [ove_pkg::TIME_W-1:0]  t;
    logic [ove_pkg::TIME_W-1:0]  dt_m;
    logic [ove_pkg::LEVEL_W-1:0] main_raw, perc_lvl, main_lvl;
    logic                        main_end;

    function automatic ove_pkg::plan_t plan_value(logic [ove_pkg::LEVEL_W-1:0] v,
                                                  logic e);
        ove_pkg::plan_t p;
        p         = '0;
        p.value   = v;
        p.ended   = e;
        return p;
    endfunction

    function automatic ove_pkg::plan_t plan_div(logic [ove_pkg::LEVEL_W-1:0] m,
                                                logic [ove_pkg::TIME_W-1:0] x,
                                                logic [ove_pkg::TIME_W-1:0] den,
                                                logic inv, logic rel);
        ove_pkg::plan_t p;
        p         = '0;
        p.use_div = 1'b1;
        p.invert  = inv;
        p.rel_end = rel;
        p.m       = m;
        p.x       = x;
        p.den     = den;
        return p;
    endfunction

    // Attack, decay, then hold at s; a zero-length segment counts as elapsed
    function automatic ove_pkg::plan_t adsr_plan(logic [ove_pkg::TIME_W-1:0] tt,
                                                 logic [ove_pkg::TIME_W-1:0] a,
                                                 logic [ove_pkg::TIME_W-1:0] d,
                                                 logic [ove_pkg::LEVEL_W-1:0] s);
        logic [ove_pkg::TIME_W-1:0] dt;
        ove_pkg::plan_t p;
        dt = tt - a;
        if (a != '0 && tt <= a)
            p = plan_div(ove_pkg::LEVEL_ONE, tt, a, 1'b0, 1'b0);
        else if (d != '0 && dt <= d)
            p = plan_div(ove_pkg::LEVEL_ONE - s, dt, d, 1'b1, 1'b0);
        else
            p = plan_value(s, 1'b0);
        return p;
    endfunction

    function automatic logic [ove_pkg::LEVEL_W-1:0] level_of(ove_pkg::plan_t p,
                                                             logic [ove_pkg::LEVEL_W-1:0] q);
        logic [ove_pkg::LEVEL_W-1:0] lv;
        if (!p.use_div)
            lv = p.value;
        else if (p.invert)
            lv = ove_pkg::LEVEL_ONE - q;
        else
            lv = q;
        return lv;
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg       <= ove_pkg::ATTACK_RST;
            decay_reg        <= ove_pkg::DECAY_RST;
            sustain_reg      <= ove_pkg::SUSTAIN_RST;
            release_reg      <= ove_pkg::RELEASE_RST;
            perc_attack_reg  <= ove_pkg::PERC_ATTACK_RST;
            perc_decay_reg   <= ove_pkg::PERC_DECAY_RST;
            perc_release_reg <= ove_pkg::PERC_RELEASE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ove_pkg::REG_ATTACK:       attack_reg       <= cfg_data;
                ove_pkg::REG_DECAY:        decay_reg        <= cfg_data;
                ove_pkg::REG_SUSTAIN:      sustain_reg      <= cfg_data[ove_pkg::LEVEL_W-1:0];
                ove_pkg::REG_RELEASE:      release_reg      <= cfg_data;
                ove_pkg::REG_PERC_ATTACK:  perc_attack_reg  <= cfg_data;
                ove_pkg::REG_PERC_DECAY:   perc_decay_reg   <= cfg_data;
                ove_pkg::REG_PERC_RELEASE: perc_release_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign voice_ok  = 32'(in_item.voice) < 32'(VOICES);
    assign in_addr   = AW'(in_item.voice);
    assign wr_addr   = AW'(item_reg.voice);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_take) state_next = S_READ;
            S_READ: state_next = S_MDIV;
            S_MDIV: if (div_rsp.done) state_next = S_PDIV;
            S_PDIV: if (div_rsp.done) state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (out_load && wr_ok_reg)
                vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Level store: read on accept, write back when the result is loaded into the output register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rd_data_reg <= mem[in_addr];
        end
        if (out_load && wr_ok_reg)
        begin
            mem[wr_addr] <= {main_lvl, perc_lvl};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg  <= in_item;
            wr_ok_reg <= voice_ok;
            rd_ok_reg <= voice_ok && vld_reg[in_addr];
        end
        if (state_reg == S_READ)
        begin
            plan_m_reg <= plan_m;
            plan_p_reg <= plan_p;
        end
        if (state_reg == S_MDIV && div_rsp.done)
            mq_reg <= div_rsp.q;
        if (state_reg == S_PDIV && div_rsp.done)
            pq_reg <= div_rsp.q;
        if (out_load)
        begin
            out_reg.voice_out   <= item_reg.voice;
            out_reg.main_level  <= main_lvl;
            out_reg.perc_level  <= perc_lvl;
            out_reg.voice_ended <= main_end;
        end
    end

    // Plan both envelopes from the stored levels and the item's time
    assign t      = item_reg.elapsed_time;
    assign dt_m   = t - attack_reg;
    assign sus    = (sustain_reg > ove_pkg::LEVEL_ONE) ? ove_pkg::LEVEL_ONE : sustain_reg;
    assign mstore = rd_ok_reg ? rd_data_reg[SW-1:ove_pkg::LEVEL_W] : '0;
    assign pstore = rd_ok_reg ? rd_data_reg[ove_pkg::LEVEL_W-1:0] : '0;

    always_comb
    begin
        if (item_reg.gate)
            plan_m = adsr_plan(t, attack_reg, decay_reg, sus);
        else if (!item_reg.pedal)
        begin
            if (release_reg > t)
                plan_m = plan_div(mstore, release_reg - t, release_reg, 1'b0, 1'b1);
            else
                plan_m = plan_value('0, 1'b1);
        end
        else if (sus != '0)
            plan_m = plan_value(sus, 1'b0);
        else if (t <= attack_reg)
            plan_m = plan_value(ove_pkg::LEVEL_ONE, 1'b0);
        else if (decay_reg == '0 || dt_m >= decay_reg)
            plan_m = plan_value('0, 1'b0);
        else
            plan_m = plan_div(ove_pkg::LEVEL_ONE, dt_m, decay_reg, 1'b1, 1'b0);

        if (item_reg.gate || item_reg.pedal)
            plan_p = adsr_plan(t, perc_attack_reg, perc_decay_reg, '0);
        else if (perc_release_reg > t)
            plan_p = plan_div(pstore, perc_release_reg - t, perc_release_reg, 1'b0, 1'b0);
        else
            plan_p = plan_value('0, 1'b0);
    end

    // Main division starts from the fresh plan, percussive from the held one
    always_comb
    begin
        div_req.start = (state_reg == S_READ) || (state_reg == S_MDIV && div_rsp.done);
        if (state_reg == S_READ)
        begin
            div_req.m   = plan_m.m;
            div_req.x   = plan_m.x;
            div_req.den = plan_m.den;
        end
        else
        begin
            div_req.m   = plan_p_reg.m;
            div_req.x   = plan_p_reg.x;
            div_req.den = plan_p_reg.den;
        end
    end

    ove_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // A release that falls below the audible floor ends the voice
    assign main_raw = level_of(plan_m_reg, mq_reg);
    assign main_end = plan_m_reg.ended ||
                      (plan_m_reg.use_div && plan_m_reg.rel_end &&
                       main_raw < ove_pkg::END_LEVEL);
    assign main_lvl = main_end ? '0 : main_raw;
    assign perc_lvl = level_of(plan_p_reg, pq_reg);

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

/* rtl/ove_check.sv */
// Port-level checker for the organ voice envelope, bound to the top level.
// Watches the item channels for handshake and level sanity.
// Depends on ove_pkg and organ_voice_envelope.
module ove_check
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input ove_pkg::in_item_t              in_item,
    input logic                           out_valid,
    input logic                           out_stall,
    input ove_pkg::out_item_t             out_item
);

    // Hold a stalled input item
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_item))
        else $error("stalled input item changed");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // One item at a time: stall the input right after an accept
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    a_end_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.voice_ended |-> out_item.main_level == '0)
        else $error("ended voice with nonzero level");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.main_level <= ove_pkg::LEVEL_ONE &&
                      out_item.perc_level <= ove_pkg::LEVEL_ONE)
        else $error("level above one");

endmodule

bind organ_voice_envelope ove_check u_ove_check (.*);

/* sim/tb_organ_voice_envelope.sv */
// Self-checking testbench for organ_voice_envelope: per-item prediction of both envelopes.
// Runs directed and random note sequences over several register settings with random stalls.
// Depends on ove_pkg and the organ_voice_envelope RTL.
module tb_organ_voice_envelope;
    timeunit 1ns;
    timeprecision 1ps;

    import ove_pkg::*;

    localparam logic [63:0] FULL_SCALE  = 64'(LEVEL_ONE);
    localparam logic [63:0] QUIET_LEVEL = 64'(END_LEVEL);
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          NUM_ENV_REGS = 7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  cfg_write = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state: register copy and per-voice level stores
    logic [31:0] env_reg [NUM_ENV_REGS];
    logic [15:0] main_store [VOICES_DEFAULT];
    logic [15:0] perc_store [VOICES_DEFAULT];

    in_item_t  note_events [$];
    out_item_t expected_levels [$];
    int        mismatch_count = 0;
    int        results_seen = 0;
    int        send_gap = 0;
    int        stall_left = 0;
    int        idle_cycles = 0;
    bit        no_gaps = 1'b0;

    organ_voice_envelope dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [15:0] limit_level(logic [63:0] v);
        return (v > FULL_SCALE) ? FULL_SCALE[15:0] : v[15:0];
    endfunction

    function automatic logic [15:0] attack_decay_level(logic [63:0] t, logic [63:0] a,
                                                       logic [63:0] d, logic [15:0] s);
        logic [63:0] dt;
        if (a != 0 && t <= a)
            return 16'((t * FULL_SCALE) / a);
        dt = t - a;
        if (t >= a && d != 0 && dt <= d)
            return 16'(FULL_SCALE - ((FULL_SCALE - 64'(s)) * dt) / d);
        return s;
    endfunction

    function automatic logic [15:0] fade_level(logic [15:0] start, logic [63:0] t,
                                               logic [63:0] r);
        if (r > t)
            return 16'((64'(start) * (r - t)) / r);
        return 16'd0;
    endfunction

    function automatic out_item_t envelope_predict(in_item_t it);
        logic [63:0] t, a, d, r, pa, pd, pr, dt;
        logic [15:0] sus, mstore, pstore, mlev, plev;
        logic        ended;
        out_item_t   res;
        t  = 64'(it.elapsed_time);
        a  = 64'(env_reg[REG_ATTACK]);
        d  = 64'(env_reg[REG_DECAY]);
        r  = 64'(env_reg[REG_RELEASE]);
        pa = 64'(env_reg[REG_PERC_ATTACK]);
        pd = 64'(env_reg[REG_PERC_DECAY]);
        pr = 64'(env_reg[REG_PERC_RELEASE]);
        sus = limit_level(64'(env_reg[REG_SUSTAIN]));
        mstore = limit_level(64'(main_store[it.voice]));
        pstore = limit_level(64'(perc_store[it.voice]));
        ended = 1'b0;

        if (it.gate)
            mlev = attack_decay_level(t, a, d, sus);
        else if (!it.pedal)
        begin
            // past the release time the fade gives zero, which also ends the voice
            mlev = fade_level(mstore, t, r);
            if (64'(mlev) < QUIET_LEVEL)
            begin
                mlev = 16'd0;
                ended = 1'b1;
            end
        end
        else if (sus != 0)
            mlev = sus;
        else if (t <= a)
            mlev = FULL_SCALE[15:0];
        else
        begin
            dt = t - a;
            if (d == 0 || dt >= d)
                mlev = 16'd0;
            else
                mlev = 16'(FULL_SCALE - (FULL_SCALE * dt) / d);
        end

        if (it.gate || it.pedal)
            plev = attack_decay_level(t, pa, pd, 16'd0);
        else
            plev = fade_level(pstore, t, pr);

        main_store[it.voice] = mlev;
        perc_store[it.voice] = plev;

        res.voice_out   = it.voice;
        res.main_level  = mlev;
        res.perc_level  = plev;
        res.voice_ended = ended;
        return res;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 45);
        return $urandom_range(80, 250);
    endfunction

    function automatic logic [63:0] rand_below(logic [63:0] lim);
        if (lim == 0)
            return 64'd0;
        return {$urandom(), $urandom()} % lim;
    endfunction

    function automatic logic [31:0] rand_duration();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom();
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 67108864);
        endcase
    endfunction

    function automatic logic [31:0] rand_sustain();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'(FULL_SCALE);
            2: return $urandom_range(32769, 65535);
            default: return $urandom_range(0, 32768);
        endcase
    endfunction

    task automatic add_event(logic [4:0] v, logic g, logic p, logic [63:0] t);
        in_item_t it;
        it.voice        = v;
        it.gate         = g;
        it.pedal        = p;
        it.elapsed_time = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
        note_events.push_back(it);
    endtask

    // One note: key held through attack and decay, then released until the voice ends
    task automatic push_note();
        logic [4:0]  v;
        int unsigned n_on, n_off;
        logic        ped, ped_off;
        logic [63:0] span, rel;
        v = 5'($urandom_range(0, 31));
        span = 64'(env_reg[REG_ATTACK]) + 64'(env_reg[REG_DECAY]);
        span = span + span / 4 + 2;
        rel = 64'(env_reg[REG_RELEASE]);
        if (64'(env_reg[REG_PERC_RELEASE]) > rel)
            rel = 64'(env_reg[REG_PERC_RELEASE]);
        rel = rel + rel / 4 + 2;
        n_on = $urandom_range(1, 6);
        n_off = $urandom_range(2, 8);
        ped = ($urandom_range(0, 4) == 0);
        ped_off = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < n_on; k++)
            add_event(v, 1'b1, ped, (span * k) / n_on + rand_below(span / n_on + 1));
        for (int k = 0; k < n_off; k++)
            add_event(v, 1'b0, ped_off, (rel * k) / n_off + rand_below(rel / n_off + 1));
    endtask

    task automatic push_noise();
        logic [63:0] span;
        span = 64'(env_reg[REG_ATTACK]) + 64'(env_reg[REG_DECAY]) + 64'(env_reg[REG_RELEASE]);
        add_event(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  ($urandom_range(0, 1) == 1) ? 64'($urandom()) : rand_below(span + 2));
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        env_reg[idx] = (idx == REG_SUSTAIN) ? {16'd0, val[15:0]} : val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic load_config(logic [31:0] a, logic [31:0] d, logic [31:0] s, logic [31:0] r,
                               logic [31:0] pa, logic [31:0] pd, logic [31:0] pr);
        write_reg(REG_ATTACK, a);
        write_reg(REG_DECAY, d);
        // upper bits of the sustain word are dont-care
        write_reg(REG_SUSTAIN, {16'($urandom_range(0, 65535)), s[15:0]});
        write_reg(REG_RELEASE, r);
        write_reg(REG_PERC_ATTACK, pa);
        write_reg(REG_PERC_DECAY, pd);
        write_reg(REG_PERC_RELEASE, pr);
    endtask

    // Hold until every queued item has gone through and its result has been checked
    task automatic wait_idle();
        do
            @(negedge clk);
        while (note_events.size() != 0 || in_valid || expected_levels.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic random_phase(int n);
        while (note_events.size() < n)
        begin
            if ($urandom_range(0, 9) < 7)
                push_note();
            else
                push_noise();
        end
        wait_idle();
    endtask

    // Sender: present queued items, with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_levels.push_back(envelope_predict(in_item));
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (note_events.size() > 0)
                begin
                    in_item  <= note_events.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each result against the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin : receiver
        out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_levels.size() == 0)
                begin
                    $error("unexpected result item for voice %0d", out_item.voice_out);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (out_item.voice_out !== want.voice_out)
                    begin
                        $error("voice_out: expected %0d, got %0d",
                               want.voice_out, out_item.voice_out);
                        mismatch_count++;
                    end
                    if (out_item.main_level !== want.main_level)
                    begin
                        $error("main_level: expected %0d, got %0d",
                               want.main_level, out_item.main_level);
                        mismatch_count++;
                    end
                    if (out_item.perc_level !== want.perc_level)
                    begin
                        $error("perc_level: expected %0d, got %0d",
                               want.perc_level, out_item.perc_level);
                        mismatch_count++;
                    end
                    if (out_item.voice_ended !== want.voice_ended)
                    begin
                        $error("voice_ended: expected %0d, got %0d",
                               want.voice_ended, out_item.voice_ended);
                        mismatch_count++;
                    end
                end
                results_seen++;
                // long hold-off: let the block fill up and stall its input
                if (results_seen == 400 || results_seen == 1300)
                    stall_left = 600;
            end
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        env_reg[REG_ATTACK]       = 32'(ATTACK_RST);
        env_reg[REG_DECAY]        = 32'(DECAY_RST);
        env_reg[REG_SUSTAIN]      = 32'(SUSTAIN_RST);
        env_reg[REG_RELEASE]      = 32'(RELEASE_RST);
        env_reg[REG_PERC_ATTACK]  = 32'(PERC_ATTACK_RST);
        env_reg[REG_PERC_DECAY]   = 32'(PERC_DECAY_RST);
        env_reg[REG_PERC_RELEASE] = 32'(PERC_RELEASE_RST);
        for (int i = 0; i < VOICES_DEFAULT; i++)
        begin
            main_store[i] = 16'd0;
            perc_store[i] = 16'd0;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: segment edges, release from sustain, pedal hold, untouched voice
        add_event(5'd3, 1'b1, 1'b0, 64'd0);
        add_event(5'd3, 1'b1, 1'b0, 64'(ATTACK_RST));
        add_event(5'd3, 1'b1, 1'b0, 64'(ATTACK_RST) + 1);
        add_event(5'd3, 1'b1, 1'b0, 64'(ATTACK_RST) + 64'(DECAY_RST));
        add_event(5'd3, 1'b1, 1'b0, 64'hFFFF_FFFF);
        add_event(5'd3, 1'b0, 1'b0, 64'd0);
        add_event(5'd3, 1'b0, 1'b0, 64'(RELEASE_RST) / 2);
        add_event(5'd3, 1'b0, 1'b0, 64'(RELEASE_RST) - 1);
        add_event(5'd3, 1'b0, 1'b0, 64'(RELEASE_RST));
        add_event(5'd7, 1'b0, 1'b1, 64'(ATTACK_RST));
        add_event(5'd7, 1'b0, 1'b1, 64'hFFFF_FFFF);
        add_event(5'd31, 1'b1, 1'b1, 64'(ATTACK_RST) / 2);
        add_event(5'd0, 1'b0, 1'b0, 64'd1);
        wait_idle();

        // Zero durations and zero sustain: every segment already elapsed
        load_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        add_event(5'd5, 1'b1, 1'b0, 64'd0);
        add_event(5'd5, 1'b1, 1'b0, 64'hFFFF_FFFF);
        add_event(5'd5, 1'b0, 1'b1, 64'd0);
        add_event(5'd5, 1'b0, 1'b1, 64'd1);
        add_event(5'd5, 1'b0, 1'b0, 64'd0);
        wait_idle();

        // Zero sustain under the pedal, percussive decay from a zero attack
        load_config(32'd1000, 32'd4000, 32'd0, 32'd8000, 32'd0, 32'd3000, 32'd8000);
        add_event(5'd9, 1'b0, 1'b1, 64'd500);
        add_event(5'd9, 1'b0, 1'b1, 64'd3000);
        add_event(5'd9, 1'b0, 1'b1, 64'd5000);
        add_event(5'd9, 1'b1, 1'b0, 64'd5000);
        add_event(5'd9, 1'b1, 1'b0, 64'd0);
        add_event(5'd9, 1'b0, 1'b0, 64'd100);
        wait_idle();

        load_config(32'(ATTACK_RST), 32'(DECAY_RST), 32'(SUSTAIN_RST), 32'(RELEASE_RST),
                    32'(PERC_ATTACK_RST), 32'(PERC_DECAY_RST), 32'(PERC_RELEASE_RST));
        random_phase(250);

        load_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        random_phase(150);

        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'(FULL_SCALE), 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(250);

        // Sustain above full scale, run back to back with no idling
        no_gaps = 1'b1;
        load_config(32'd5000, 32'd20000, 32'h0000_FFFF, 32'd30000,
                    32'd3000, 32'd12000, 32'd25000);
        random_phase(200);
        no_gaps = 1'b0;

        repeat (4)
        begin
            load_config(rand_duration(), rand_duration(), rand_sustain(), rand_duration(),
                        rand_duration(), rand_duration(), rand_duration());
            random_phase(225);
        end

        repeat (50) @(posedge clk);
        if (expected_levels.size() != 0)
        begin
            $error("%0d result items never arrived", expected_levels.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
